// File: rtl/ets_pkg.sv
package ets_pkg;

    // payload widths
    localparam int KIND_W  = 6;
    localparam int CLASS_W = 4;
    localparam int START_W = 12;
    localparam int LEN_W   = 8;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // token kind codes
    localparam logic [KIND_W-1:0] K_ERR    = 6'd0;
    localparam logic [KIND_W-1:0] K_TRUE   = 6'd1;
    localparam logic [KIND_W-1:0] K_FALSE  = 6'd2;
    localparam logic [KIND_W-1:0] K_NULL   = 6'd3;
    localparam logic [KIND_W-1:0] K_VALUE  = 6'd10;
    localparam logic [KIND_W-1:0] K_NUM    = 6'd11;
    localparam logic [KIND_W-1:0] K_STRING = 6'd12;
    localparam logic [KIND_W-1:0] K_DATA   = 6'd13;
    localparam logic [KIND_W-1:0] K_ID     = 6'd14;
    localparam logic [KIND_W-1:0] K_COMMA  = 6'd15;
    localparam logic [KIND_W-1:0] K_LPAREN = 6'd16;
    localparam logic [KIND_W-1:0] K_RPAREN = 6'd17;
    localparam logic [KIND_W-1:0] K_NOT    = 6'd18;
    localparam logic [KIND_W-1:0] K_MINUS  = 6'd19;
    localparam logic [KIND_W-1:0] K_PLUS   = 6'd20;
    localparam logic [KIND_W-1:0] K_MOD    = 6'd21;
    localparam logic [KIND_W-1:0] K_DIV    = 6'd22;
    localparam logic [KIND_W-1:0] K_MUL    = 6'd23;
    localparam logic [KIND_W-1:0] K_GT     = 6'd24;
    localparam logic [KIND_W-1:0] K_LT     = 6'd25;
    localparam logic [KIND_W-1:0] K_GE     = 6'd26;
    localparam logic [KIND_W-1:0] K_LE     = 6'd27;
    localparam logic [KIND_W-1:0] K_EQEQ   = 6'd28;
    localparam logic [KIND_W-1:0] K_NE     = 6'd29;
    localparam logic [KIND_W-1:0] K_ANDAND = 6'd30;
    localparam logic [KIND_W-1:0] K_OROR   = 6'd31;
    localparam logic [KIND_W-1:0] K_QUEST  = 6'd32;
    localparam logic [KIND_W-1:0] K_COLON  = 6'd33;
    localparam logic [KIND_W-1:0] K_ELVIS  = 6'd34;
    localparam logic [KIND_W-1:0] K_HASH   = 6'd35;
    localparam logic [KIND_W-1:0] K_FUNC   = 6'd36;

    // token classes
    localparam logic [CLASS_W-1:0] C_OP    = 4'd0;
    localparam logic [CLASS_W-1:0] C_BOOL  = 4'd1;
    localparam logic [CLASS_W-1:0] C_NULL  = 4'd2;
    localparam logic [CLASS_W-1:0] C_VALUE = 4'd3;
    localparam logic [CLASS_W-1:0] C_NUM   = 4'd4;
    localparam logic [CLASS_W-1:0] C_STR   = 4'd5;
    localparam logic [CLASS_W-1:0] C_DATA  = 4'd6;
    localparam logic [CLASS_W-1:0] C_ID    = 4'd7;
    localparam logic [CLASS_W-1:0] C_FUNC  = 4'd8;
    localparam logic [CLASS_W-1:0] C_ERR   = 4'd9;

    // keywords: true, false, null
    localparam int KW_N = 3;
    localparam logic [7:0] KW_TEXT [KW_N][8] = '{
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int KW_LEN [KW_N] = '{4, 5, 4};
    localparam logic [KIND_W-1:0]  KW_KIND [KW_N] = '{K_TRUE, K_FALSE, K_NULL};
    localparam logic [CLASS_W-1:0] KW_CLS  [KW_N] = '{C_BOOL, C_BOOL, C_NULL};

    // scanner modes
    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_DOLLAR = 15'b000000000000010,
        S_VALUE  = 15'b000000000000100,
        S_IDENT  = 15'b000000000001000,
        S_PAREN  = 15'b000000000010000,
        S_NUM    = 15'b000000000100000,
        S_NUMPT  = 15'b000000001000000,
        S_STRING = 15'b000000010000000,
        S_QUEST  = 15'b000000100000000,
        S_LT     = 15'b000001000000000,
        S_GT     = 15'b000010000000000,
        S_AMP    = 15'b000100000000000,
        S_BANG   = 15'b001000000000000,
        S_BAR    = 15'b010000000000000,
        S_EQ     = 15'b100000000000000
    } t_mode;

    // one finished token
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CLASS_W-1:0] cls;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               last;
    } t_tok;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

endpackage

// File: rtl/expression_token_scanner_core.sv
// queueing: tokens finished by a character enter the result queue at the accepting edge; the
//   queue head drives the output directly, with no output register
// throughput: one character per cycle while o_stall is low; each character yields 0 to 3 results,
//   drained one per cycle unless i_stall from an 8-entry queue; input stalls while fewer than 3 queue entries are free
// reset: synchronous active low, scanner returns to idle at offset 0, queue empties at once
module expression_token_scanner_core #(
    parameter int MAX_TEXT_LEN  = 4096,
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_char_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ets_pkg::KIND_W-1:0]   o_kind,
    output logic [ets_pkg::CLASS_W-1:0]  o_token_class,
    output logic [ets_pkg::START_W-1:0]  o_start_offset,
    output logic [ets_pkg::LEN_W-1:0]    o_token_length,
    output logic                         o_last_of_run
);
    import ets_pkg::*;

    localparam int PW  = $clog2(MAX_TEXT_LEN);
    localparam int SW  = $clog2(MAX_TEXT_LEN + 1);
    localparam int TCW = $clog2(MAX_TOKEN_LEN + 1);

    // scanner state
    t_mode              r_mode, n_mode;
    logic [PW-1:0]      r_pos, n_pos;
    logic [SW-1:0]      r_tstart, n_tstart;
    logic [TCW-1:0]     r_count, n_count;
    logic [KW_N-1:0]    r_kw, n_kw;
    logic               r_err, n_err;
    logic               r_pt, n_pt;
    logic               r_space, n_space;

    // result queue
    t_tok               r_q [QUEUE_DEPTH];
    logic [QPW-1:0]     r_wr, r_rd;
    logic [QCW-1:0]     r_cnt;

    logic               in_acc;
    logic               pop;
    logic [7:0]         c;
    logic               taken;
    logic [SW-1:0]      pos_ext;
    logic [2:0]         e_v;
    t_tok               e_tok [3];
    t_tok               w_tok [3];
    logic [QPW-1:0]     w_idx [3];
    logic [1:0]         push_n;
    logic               kw_hit;
    logic [KIND_W-1:0]  kw_kind;
    logic [CLASS_W-1:0] kw_cls;
    logic [7:0]         p_sec;
    logic [KIND_W-1:0]  p_k2, p_k1;
    logic               p_swal;

    function automatic logic [TCW-1:0] grow(input logic [TCW-1:0] n);
        return (32'(n) < 32'(MAX_TOKEN_LEN)) ? n + TCW'(1) : n;
    endfunction

    function automatic logic [LEN_W-1:0] len_sat(input logic [TCW-1:0] n);
        return (32'(n) > 32'd255) ? 8'hFF : LEN_W'(n);
    endfunction

    function automatic t_tok mk_tok(input logic [KIND_W-1:0] kind,
                                    input logic [CLASS_W-1:0] cls,
                                    input logic [SW-1:0] start,
                                    input logic [LEN_W-1:0] len);
        t_tok tok;
        tok.kind  = kind;
        tok.cls   = cls;
        tok.start = START_W'(start);
        tok.len   = len;
        tok.last  = 1'b0;
        return tok;
    endfunction

    // drop keywords whose next letter does not match
    function automatic logic [KW_N-1:0] kw_step(input logic [KW_N-1:0] kw,
                                                input logic [TCW-1:0] n,
                                                input logic [7:0] ch);
        logic [KW_N-1:0] res;
        res = kw;
        for (int i = 0; i < KW_N; i++) begin
            if (kw[i] && !(32'(n) < KW_LEN[i] && KW_TEXT[i][n[2:0]] == ch)) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic is_val(input logic [7:0] ch);
        return is_digit(ch) || is_alpha(ch) || ch == "[" || ch == "]" || ch == ".";
    endfunction

    assign in_acc  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign c       = i_char_byte;
    assign pos_ext = SW'(r_pos);

    // finished keyword lookup
    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = K_ERR;
        kw_cls  = C_ERR;
        for (int i = KW_N - 1; i >= 0; i--) begin
            if (r_kw[i] && 32'(r_count) == KW_LEN[i]) begin
                kw_hit  = 1'b1;
                kw_kind = KW_KIND[i];
                kw_cls  = KW_CLS[i];
            end
        end
    end

    // one- and two-character operator table
    always_comb begin
        p_sec  = "=";
        p_k2   = K_ERR;
        p_k1   = K_ERR;
        p_swal = 1'b0;
        unique case (r_mode)
            S_QUEST: begin
                p_sec = ":";
                p_k2  = K_ELVIS;
                p_k1  = K_QUEST;
            end
            S_LT: begin
                p_k2 = K_LE;
                p_k1 = K_LT;
            end
            S_GT: begin
                p_k2 = K_GE;
                p_k1 = K_GT;
            end
            S_AMP: begin
                p_sec = "&";
                p_k2  = K_ANDAND;
            end
            S_BANG: begin
                p_k2 = K_NE;
                p_k1 = K_NOT;
            end
            S_BAR: begin
                p_sec  = "|";
                p_k2   = K_OROR;
                p_swal = 1'b1;
            end
            S_EQ: begin
                p_k2   = K_EQEQ;
                p_swal = 1'b1;
            end
            default: begin
                p_swal = 1'b0;
            end
        endcase
    end

    // per-character scan step
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_count  = r_count;
        n_kw     = r_kw;
        n_err    = r_err;
        n_pt     = r_pt;
        n_space  = r_space;
        e_v      = '0;
        e_tok[0] = mk_tok(K_ERR, C_ERR, '0, '0);
        e_tok[1] = mk_tok(K_ERR, C_ERR, '0, '0);
        e_tok[2] = mk_tok(K_ERR, C_ERR, '0, '0);
        taken    = 1'b0;

        if (in_acc) begin
            // finish or extend a pending token
            if (r_mode != S_IDLE) begin
                unique case (r_mode)
                    S_DOLLAR: begin
                        if (c == "$") begin
                            e_v[0]   = 1'b1;
                            e_tok[0] = mk_tok(K_DATA, C_DATA, r_tstart, 8'd2);
                            n_mode   = S_IDLE;
                            taken    = 1'b1;
                        end else begin
                            n_tstart = pos_ext;
                            n_count  = '0;
                            n_err    = 1'b0;
                            n_pt     = 1'b0;
                            if (is_val(c)) begin
                                n_count = grow('0);
                                n_mode  = S_VALUE;
                                taken   = 1'b1;
                            end else begin
                                // empty value
                                e_v[0]   = 1'b1;
                                e_tok[0] = mk_tok(K_VALUE, C_VALUE, pos_ext, 8'd0);
                                n_mode   = S_IDLE;
                            end
                        end
                    end
                    S_VALUE: begin
                        if (is_val(c)) begin
                            n_count = grow(r_count);
                            taken   = 1'b1;
                        end else begin
                            e_v[0]   = 1'b1;
                            e_tok[0] = mk_tok(K_VALUE, C_VALUE, r_tstart, len_sat(r_count));
                            n_mode   = S_IDLE;
                        end
                    end
                    S_IDENT: begin
                        if (is_digit(c) || is_alpha(c)) begin
                            n_kw    = kw_step(r_kw, r_count, c);
                            n_count = grow(r_count);
                            taken   = 1'b1;
                        end else begin
                            n_mode = S_IDLE;
                            if (kw_hit) begin
                                e_v[0]   = 1'b1;
                                e_tok[0] = mk_tok(kw_kind, kw_cls, r_tstart, len_sat(r_count));
                            end else if (c == "(") begin
                                n_mode = S_PAREN;
                                taken  = 1'b1;
                            end else begin
                                e_v[0]   = 1'b1;
                                e_tok[0] = mk_tok(K_ID, C_ID, r_tstart, len_sat(r_count));
                            end
                        end
                    end
                    S_PAREN: begin
                        n_mode   = S_IDLE;
                        e_v[0]   = 1'b1;
                        if (c == ")") begin
                            e_tok[0] = mk_tok(K_FUNC, C_FUNC, r_tstart, len_sat(r_count));
                            taken    = 1'b1;
                        end else begin
                            // identifier, then the held open paren
                            e_tok[0] = mk_tok(K_ID, C_ID, r_tstart, len_sat(r_count));
                            e_v[1]   = 1'b1;
                            e_tok[1] = mk_tok(K_LPAREN, C_OP, pos_ext - SW'(1), 8'd1);
                        end
                    end
                    S_NUM, S_NUMPT: begin
                        // a point must be followed by a digit
                        n_err  = r_err || (r_mode == S_NUMPT && !is_digit(c));
                        n_mode = S_NUM;
                        if (is_digit(c)) begin
                            n_count = grow(r_count);
                            taken   = 1'b1;
                        end else if (is_alpha(c)) begin
                            n_err   = 1'b1;
                            n_count = grow(r_count);
                            taken   = 1'b1;
                        end else if (c == ".") begin
                            if (r_pt) begin
                                n_err = 1'b1;
                            end else begin
                                n_pt   = 1'b1;
                                n_mode = S_NUMPT;
                            end
                            n_count = grow(r_count);
                            taken   = 1'b1;
                        end else begin
                            e_v[0] = 1'b1;
                            if (n_err) begin
                                e_tok[0] = mk_tok(K_ERR, C_ERR, r_tstart, len_sat(r_count));
                            end else begin
                                e_tok[0] = mk_tok(K_NUM, C_NUM, r_tstart, len_sat(r_count));
                            end
                            n_mode = S_IDLE;
                        end
                    end
                    S_STRING: begin
                        taken = 1'b1;
                        if (c == "'") begin
                            e_v[0]   = 1'b1;
                            e_tok[0] = mk_tok(K_STRING, C_STR, r_tstart, len_sat(r_count));
                            n_mode   = S_IDLE;
                        end else if (c == 8'd0) begin
                            // unterminated string
                            e_v[0]   = 1'b1;
                            e_tok[0] = mk_tok(K_ERR, C_ERR, r_tstart, len_sat(r_count));
                            n_mode   = S_IDLE;
                        end else begin
                            n_count = grow(r_count);
                        end
                    end
                    default: begin
                        // one- or two-character operators
                        n_mode = S_IDLE;
                        e_v[0] = 1'b1;
                        if (c == p_sec) begin
                            e_tok[0] = mk_tok(p_k2, C_OP, r_tstart, 8'd2);
                            taken    = 1'b1;
                        end else if (p_swal) begin
                            e_tok[0] = mk_tok(K_ERR, C_ERR, r_tstart,
                                              (c == 8'd0) ? 8'd1 : 8'd2);
                            taken    = 1'b1;
                        end else begin
                            e_tok[0] = mk_tok(p_k1, C_OP, r_tstart, 8'd1);
                        end
                    end
                endcase
            end

            if (c == 8'd0) begin
                // end of text: back to reset state
                n_mode   = S_IDLE;
                n_pos    = '0;
                n_tstart = '0;
                n_count  = '0;
                n_kw     = '1;
                n_err    = 1'b0;
                n_pt     = 1'b0;
                n_space  = 1'b0;
            end else begin
                // start a new token
                if (!taken) begin
                    if (c == " " && !r_space) begin
                        n_space = 1'b1;
                    end else begin
                        n_space = 1'b0;
                        priority if (c == "$") begin
                            n_tstart = pos_ext;
                            n_mode   = S_DOLLAR;
                        end else if (is_alpha(c)) begin
                            n_tstart = pos_ext;
                            n_err    = 1'b0;
                            n_pt     = 1'b0;
                            n_kw     = kw_step('1, '0, c);
                            n_count  = grow('0);
                            n_mode   = S_IDENT;
                        end else if (is_digit(c)) begin
                            n_tstart = pos_ext;
                            n_err    = 1'b0;
                            n_pt     = 1'b0;
                            n_count  = grow('0);
                            n_mode   = S_NUM;
                        end else if (c == "'") begin
                            n_tstart = pos_ext + SW'(1);
                            n_err    = 1'b0;
                            n_pt     = 1'b0;
                            n_count  = '0;
                            n_mode   = S_STRING;
                        end else begin
                            unique case (c)
                                ",": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_COMMA, C_OP, pos_ext, 8'd1);
                                end
                                "(": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_LPAREN, C_OP, pos_ext, 8'd1);
                                end
                                ")": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_RPAREN, C_OP, pos_ext, 8'd1);
                                end
                                "-": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_MINUS, C_OP, pos_ext, 8'd1);
                                end
                                "+": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_PLUS, C_OP, pos_ext, 8'd1);
                                end
                                "%": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_MOD, C_OP, pos_ext, 8'd1);
                                end
                                "/": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_DIV, C_OP, pos_ext, 8'd1);
                                end
                                "*": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_MUL, C_OP, pos_ext, 8'd1);
                                end
                                ":": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_COLON, C_OP, pos_ext, 8'd1);
                                end
                                "#": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_HASH, C_NULL, pos_ext, 8'd1);
                                end
                                "~": begin
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_FUNC, C_NULL, pos_ext, 8'd1);
                                end
                                "?": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_QUEST;
                                end
                                "<": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_LT;
                                end
                                ">": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_GT;
                                end
                                "&": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_AMP;
                                end
                                "!": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_BANG;
                                end
                                "|": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_BAR;
                                end
                                "=": begin
                                    n_tstart = pos_ext;
                                    n_mode   = S_EQ;
                                end
                                default: begin
                                    // also a second space in a row
                                    e_v[2] = 1'b1;
                                    e_tok[2] = mk_tok(K_ERR, C_ERR, pos_ext, 8'd1);
                                end
                            endcase
                        end
                    end
                end
                // position saturates at the last offset
                if (32'(r_pos) < MAX_TEXT_LEN - 1) begin
                    n_pos = r_pos + PW'(1);
                end
            end
        end
    end

    // pack results in order and mark the last one
    always_comb begin
        w_tok[0]      = e_tok[0];
        w_tok[1]      = e_tok[1];
        w_tok[2]      = e_tok[2];
        w_tok[0].last = !e_v[1] && !e_v[2];
        w_tok[1].last = !e_v[2];
        w_tok[2].last = 1'b1;
        w_idx[0]      = r_wr;
        w_idx[1]      = r_wr + QPW'(e_v[0]);
        w_idx[2]      = r_wr + QPW'(e_v[0]) + QPW'(e_v[1]);
        push_n        = 2'(e_v[0]) + 2'(e_v[1]) + 2'(e_v[2]);
    end

    // scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_count  <= '0;
            r_kw     <= '1;
            r_err    <= 1'b0;
            r_pt     <= 1'b0;
            r_space  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_count  <= n_count;
            r_kw     <= n_kw;
            r_err    <= n_err;
            r_pt     <= n_pt;
            r_space  <= n_space;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (e_v[k]) begin
                r_q[w_idx[k]] <= w_tok[k];
            end
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QPW'(push_n);
            r_rd  <= r_rd + QPW'(pop);
            r_cnt <= r_cnt + QCW'(push_n) - QCW'(pop);
        end
    end

    assign o_stall        = r_cnt > QCW'(QUEUE_DEPTH - 3);
    assign o_valid        = r_cnt != '0;
    assign o_kind         = r_q[r_rd].kind;
    assign o_token_class  = r_q[r_rd].cls;
    assign o_start_offset = r_q[r_rd].start;
    assign o_token_length = r_q[r_rd].len;
    assign o_last_of_run  = r_q[r_rd].last;

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // end of text returns the scanner to offset zero, idle
    a_eot_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_char_byte == 8'd0) |=> (r_mode == S_IDLE && r_pos == '0 && !r_space))
        else $error("scanner not idle after end of text");

    // a transaction that finishes no token, with no pop, leaves the queue fill unchanged
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_v == 3'b000 && !pop) |=> $stable(r_cnt))
        else $error("queue fill changed with no result");

    // a second pending result only comes from a held open paren, after the identifier
    a_two_from_paren: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_v[1] |-> (r_mode == S_PAREN && e_v[0]))
        else $error("unexpected second pending result");

endmodule
